@@ rtl/core/dds_pkg.sv @@
// ----------------------------------------------------------------------------
// dds_pkg
// Types, codes and constants shared by the decimal digit sprite layout block.
// ----------------------------------------------------------------------------
package dds_pkg;

  localparam int MAX_SLOTS_DEFAULT = 10;
  localparam int DIGIT_MAX = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHEET_TOP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NEG_ROW_EN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_LIMIT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_MODE = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGN_ENABLE = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGN_GAP = 3'd7;

  localparam logic [1:0] FILL_NONE = 2'd0;
  localparam logic [1:0] FILL_ZERO = 2'd1;
  localparam logic [1:0] FILL_SPACE = 2'd2;

  localparam logic [1:0] KIND_SIGN = 2'd0;
  localparam logic [1:0] KIND_DIGIT = 2'd1;
  localparam logic [1:0] KIND_FILLER = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [11:0] sheet_top;
    logic        negative_row_enable;
    logic [3:0]  digit_limit;
    logic [1:0]  fill_mode;
    logic        sign_enable;
    logic [7:0]  sign_gap;
  } cfg_t;

  typedef struct packed {
    logic [DIGIT_MAX-1:0][3:0] digits;
    logic [3:0]                total;
    logic                      neg;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } queue_wr_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    item_t head;
  } queue_st_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SIGN,
    B_OVF,
    B_ZERO,
    B_DIGIT
  } back_state_t;

endpackage

@@ rtl/core/dds_in_if.sv @@
// ----------------------------------------------------------------------------
// dds_in_if
// Number channel: valid/ready handshake with a signed 32-bit value.
// ----------------------------------------------------------------------------
interface dds_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

@@ rtl/core/dds_out_if.sv @@
// ----------------------------------------------------------------------------
// dds_out_if
// Glyph record channel: valid/ready handshake with one layout record.
// ----------------------------------------------------------------------------
interface dds_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  glyph_kind;
  logic [3:0]  glyph_slot;
  logic [11:0] source_x;
  logic [12:0] source_y;
  logic [11:0] draw_x;
  logic [11:0] panel_width;
  logic        overflow;
  logic        last;

  modport source (
    output valid, output glyph_kind, output glyph_slot, output source_x,
    output source_y, output draw_x, output panel_width, output overflow,
    output last, input ready
  );
  modport sink (
    input valid, input glyph_kind, input glyph_slot, input source_x,
    input source_y, input draw_x, input panel_width, input overflow,
    input last, output ready
  );
endinterface

@@ rtl/core/dds_front.sv @@
// ----------------------------------------------------------------------------
// dds_front
// Accepts a number, takes its magnitude and splits it into decimal digits,
// one digit per cycle, then hands the digit set to the queue.
// ----------------------------------------------------------------------------
module dds_front (
  input  logic               clk,
  input  logic               rst,
  dds_in_if.sink             numbers,
  output dds_pkg::queue_wr_t qwr,
  input  dds_pkg::queue_st_t qst
);
  import dds_pkg::*;

  front_state_t state, state_next;
  logic [31:0] m;
  logic        neg;
  logic [3:0]  total;
  logic [DIGIT_MAX-1:0][3:0] digits;

  logic [63:0] prod;
  logic [28:0] q;
  logic [3:0]  q10_lo;
  logic [3:0]  d;
  logic        conv_done;

  assign prod = {32'd0, m} * {32'd0, RECIP_TEN};
  assign q = prod[63:35];
  assign q10_lo = {q[0], 3'b000} + {q[2:0], 1'b0};
  assign d = m[3:0] - q10_lo;
  assign conv_done = (q == 29'd0) || (total == 4'(DIGIT_MAX - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    numbers.ready = 1'b0;
    qwr.push = 1'b0;
    qwr.item.digits = digits;
    qwr.item.total = total;
    qwr.item.neg = neg;
    case (state)
      F_IDLE: begin
        numbers.ready = 1'b1;
        if (numbers.valid) begin
          state_next = F_CONV;
        end
      end
      F_CONV: begin
        if (conv_done) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!qst.full) begin
          qwr.push = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && numbers.valid) begin
      neg <= numbers.value[31];
      m <= numbers.value[31] ? (32'd0 - numbers.value) : numbers.value;
      total <= 4'd0;
    end else if (state == F_CONV) begin
      digits[total] <= d;
      total <= total + 4'd1;
      m <= {3'b000, q};
    end
  end
endmodule

@@ rtl/core/dds_queue.sv @@
// ----------------------------------------------------------------------------
// dds_queue
// Short queue of digit sets between the converter and the record emitter.
// ----------------------------------------------------------------------------
module dds_queue (
  input  logic               clk,
  input  logic               rst,
  input  dds_pkg::queue_wr_t qwr,
  input  logic               pop,
  output dds_pkg::queue_st_t qst
);
  import dds_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign qst.empty = (count == CNT_W'(0));
  assign qst.full = (count == CNT_W'(QUEUE_DEPTH));
  assign qst.head = entries[rd_ptr];
  assign do_push = qwr.push && !qst.full;
  assign do_pop = pop && !qst.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= qwr.item;
    end
  end
endmodule

@@ rtl/core/dds_back.sv @@
// ----------------------------------------------------------------------------
// dds_back
// Takes a digit set, works out the layout of the panel and emits one glyph
// record per cycle into an output register while the receiver accepts them.
// ----------------------------------------------------------------------------
module dds_back #(
  parameter int MAX_SLOTS = dds_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  dds_pkg::cfg_t      cfg,
  input  dds_pkg::queue_st_t qst,
  output logic               pop,
  dds_out_if.source          records
);
  import dds_pkg::*;

  back_state_t state, state_next;

  // per-item layout registers
  logic [DIGIT_MAX-1:0][3:0] digits;
  logic [3:0]  total;
  logic [3:0]  limit;
  logic [3:0]  nz;
  logic        ovf;
  logic [12:0] sy;
  logic [11:0] zpos;
  logic [11:0] dpos;
  logic [3:0]  cnt;
  logic [11:0] panel_width_reg;

  // output register
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [3:0]  out_slot;
  logic [11:0] out_sx;
  logic [12:0] out_sy;
  logic [11:0] out_dx;
  logic        out_last;
  logic        advance;

  // setup from the queue head
  logic [3:0]  s_limit;
  logic        s_ovf;
  logic [3:0]  s_nfill;
  logic [3:0]  s_nsum;
  logic [8:0]  s_sign_off;
  logic [11:0] s_span;
  logic [11:0] s_panel;
  logic [12:0] s_sy;
  logic        s_fill;

  // record being built
  logic        rec_valid;
  logic [1:0]  rec_kind;
  logic [3:0]  rec_slot;
  logic [11:0] rec_sx;
  logic [12:0] rec_sy;
  logic [11:0] rec_dx;
  logic        rec_last;
  logic [11:0] digit_sx;

  assign advance = !out_valid || records.ready;

  always_comb begin
    s_limit = (cfg.digit_limit > 4'(MAX_SLOTS)) ? 4'(MAX_SLOTS) : cfg.digit_limit;
    s_ovf = qst.head.total > s_limit;
    s_fill = (cfg.fill_mode == FILL_ZERO) || (cfg.fill_mode == FILL_SPACE);
    s_nfill = (s_fill && !s_ovf) ? (s_limit - qst.head.total) : 4'd0;
    s_nsum = qst.head.total + s_nfill;
    s_sign_off = cfg.sign_enable ? ({1'b0, cfg.glyph_width} + {1'b0, cfg.sign_gap}) : 9'd0;
    s_span = 12'({8'd0, s_nsum} * {4'd0, cfg.glyph_width});
    s_panel = s_span + {3'd0, s_sign_off};
    s_sy = {1'b0, cfg.sheet_top} +
           ((qst.head.neg && cfg.negative_row_enable) ? {5'd0, cfg.glyph_height} : 13'd0);
  end

  assign digit_sx = 12'({8'd0, digits[cnt]} * {4'd0, cfg.glyph_width});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
      panel_width_reg <= '0;
    end else begin
      state <= state_next;
      if (advance) begin
        out_valid <= rec_valid;
      end
      if (state == B_IDLE && advance && !qst.empty && !s_ovf) begin
        panel_width_reg <= s_panel;
      end
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    rec_valid = 1'b0;
    rec_kind = KIND_DIGIT;
    rec_slot = cnt;
    rec_sx = digit_sx;
    rec_sy = sy;
    rec_dx = dpos;
    rec_last = 1'b0;
    if (advance) begin
      case (state)
        B_IDLE: begin
          if (!qst.empty) begin
            pop = 1'b1;
            if (cfg.sign_enable) begin
              state_next = B_SIGN;
            end else if (s_ovf) begin
              state_next = B_OVF;
            end else if (cfg.fill_mode == FILL_ZERO && s_nfill != 4'd0) begin
              state_next = B_ZERO;
            end else begin
              state_next = B_DIGIT;
            end
          end
        end
        B_SIGN: begin
          rec_valid = 1'b1;
          rec_kind = KIND_SIGN;
          rec_slot = 4'(MAX_SLOTS);
          rec_sx = 12'({4'd0, cfg.glyph_width} * 12'd10);
          rec_dx = 12'd0;
          if (ovf) begin
            state_next = B_OVF;
          end else if (nz != 4'd0) begin
            state_next = B_ZERO;
          end else begin
            state_next = B_DIGIT;
          end
        end
        B_OVF: begin
          rec_valid = 1'b1;
          rec_kind = KIND_NONE;
          rec_slot = 4'd0;
          rec_sx = 12'd0;
          rec_sy = 13'd0;
          rec_dx = 12'd0;
          rec_last = 1'b1;
          state_next = B_IDLE;
        end
        B_ZERO: begin
          rec_valid = 1'b1;
          rec_kind = KIND_FILLER;
          rec_slot = limit - cnt - 4'd1;
          rec_sx = 12'd0;
          rec_dx = zpos;
          if (cnt == nz - 4'd1) begin
            state_next = B_DIGIT;
          end
        end
        B_DIGIT: begin
          rec_valid = 1'b1;
          if (cnt == total - 4'd1) begin
            rec_last = 1'b1;
            state_next = B_IDLE;
          end
        end
        default: state_next = B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind <= rec_kind;
      out_slot <= rec_slot;
      out_sx <= rec_sx;
      out_sy <= rec_sy;
      out_dx <= rec_dx;
      out_last <= rec_last;
      case (state)
        B_IDLE: begin
          if (!qst.empty) begin
            digits <= qst.head.digits;
            total <= qst.head.total;
            limit <= s_limit;
            ovf <= s_ovf;
            nz <= (cfg.fill_mode == FILL_ZERO) ? s_nfill : 4'd0;
            sy <= s_sy;
            zpos <= {3'd0, s_sign_off};
            dpos <= s_panel - {4'd0, cfg.glyph_width};
            cnt <= 4'd0;
          end
        end
        B_ZERO: begin
          zpos <= zpos + {4'd0, cfg.glyph_width};
          cnt <= (cnt == nz - 4'd1) ? 4'd0 : cnt + 4'd1;
        end
        B_DIGIT: begin
          dpos <= dpos - {4'd0, cfg.glyph_width};
          cnt <= cnt + 4'd1;
        end
        default: begin
        end
      endcase
    end
  end

  assign records.valid = out_valid;
  assign records.glyph_kind = out_kind;
  assign records.glyph_slot = out_slot;
  assign records.source_x = out_sx;
  assign records.source_y = out_sy;
  assign records.draw_x = out_dx;
  assign records.panel_width = panel_width_reg;
  assign records.overflow = ovf;
  assign records.last = out_last;
endmodule

@@ rtl/core/decimal_digit_sprite_layout_top.sv @@
// Throughput: one record per cycle while the receiver takes them. The
// one-digit-per-cycle divide-by-ten loop in front and the setup plus up
// to eleven records in back overlap through a two-entry queue.
// Reset: synchronous, active high; configuration returns to its defaults
// and the panel width to zero.
// ----------------------------------------------------------------------------
// decimal_digit_sprite_layout_top
// Splits a signed number into decimal digits and emits glyph layout records.
// ----------------------------------------------------------------------------
module decimal_digit_sprite_layout_top #(
  parameter int MAX_SLOTS = dds_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dds_pkg::CFG_DATA_W-1:0]  cfg_data,
  dds_in_if.sink                          numbers,
  dds_out_if.source                       records
);
  import dds_pkg::*;

  cfg_t      cfg;
  queue_wr_t qwr;
  queue_st_t qst;
  logic      pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_width <= 8'd8;
      cfg.glyph_height <= 8'd8;
      cfg.sheet_top <= 12'd0;
      cfg.negative_row_enable <= 1'b0;
      cfg.digit_limit <= 4'd10;
      cfg.fill_mode <= FILL_NONE;
      cfg.sign_enable <= 1'b0;
      cfg.sign_gap <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GLYPH_WIDTH: cfg.glyph_width <= cfg_data[7:0];
        REG_GLYPH_HEIGHT: cfg.glyph_height <= cfg_data[7:0];
        REG_SHEET_TOP: cfg.sheet_top <= cfg_data[11:0];
        REG_NEG_ROW_EN: cfg.negative_row_enable <= cfg_data[0];
        REG_DIGIT_LIMIT: cfg.digit_limit <= cfg_data[3:0];
        REG_FILL_MODE: cfg.fill_mode <= cfg_data[1:0];
        REG_SIGN_ENABLE: cfg.sign_enable <= cfg_data[0];
        REG_SIGN_GAP: cfg.sign_gap <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  dds_front u_front (
    .clk     (clk),
    .rst     (rst),
    .numbers (numbers),
    .qwr     (qwr),
    .qst     (qst)
  );

  dds_queue u_queue (
    .clk (clk),
    .rst (rst),
    .qwr (qwr),
    .pop (pop),
    .qst (qst)
  );

  dds_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .qst     (qst),
    .pop     (pop),
    .records (records)
  );
endmodule
